// File: rtl/asa_pkg.sv
package asa_pkg;

  // stream field widths
  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int IN_W     = TIME_W + SAMPLE_W;
  localparam int RAW_W    = 16;
  localparam int VOLT_W   = 32;
  localparam int PCT_W    = 16;
  localparam int OUT_W    = RAW_W + VOLT_W + PCT_W + VOLT_W;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // conversion constants
  localparam logic [15:0] POS_FULL_SCALE = 16'd32767;
  localparam logic [15:0] WRAP_SCALE     = 16'd65535;
  localparam logic [13:0] PCT_SCALE      = 14'd10000;

  // register reset values
  localparam logic [7:0]  NUM_SAMPLES_RST = 8'd1;
  localparam logic [15:0] MAX_VCC_RST     = 16'd3300;
  localparam logic [15:0] NEG_RES_RST     = 16'd32767;

  // shared divider sizing
  localparam int DIVD_W    = 48;
  localparam int DIVS_W    = 16;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  // queue between front and back end
  localparam int Q_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_INTERVAL    = 3'd1,
    REG_NUM_SAMPLES = 3'd2,
    REG_MAX_VCC     = 3'd3,
    REG_NEG_RES     = 3'd4,
    REG_DIV_RA      = 3'd5,
    REG_DIV_RB      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic        enable;
    logic [31:0] interval_ms;
    logic [7:0]  num_samples;
    logic [15:0] max_vcc_mv;
    logic [15:0] neg_resolution;
    logic [15:0] divider_ra;
    logic [15:0] divider_rb;
  } cfg_t;

  // one classified request: report last reading, or finish a new one
  typedef struct packed {
    logic             fin;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] n;
  } q_item_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_AVG,
    BK_VMUL,
    BK_VDIV,
    BK_PMUL,
    BK_PDIV,
    BK_SMUL,
    BK_SDIV,
    BK_EMIT
  } bk_state_t;

endpackage

// File: rtl/adc_sample_averager_scaler.sv
// adc_sample_averager_scaler: oversampling average with millivolt, percent and divider scaling
// a request that completes no reading goes through the queue and the output register, back end idle
// a completing request runs one shared 48-step divider for the average, negative-range millivolts
// and divider correction; full-scale divisions use a combinational fold
// throughput: one request per cycle otherwise if out_tready holds; queued while back end converts
// reset: synchronous active-low rst_n restores register defaults and clears mark, sum, last reading
module adc_sample_averager_scaler import asa_pkg::*; #(
  parameter int QUEUE_DEPTH = Q_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // time_ms[31:0], sample[47:32]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // raw_avg[15:0], voltage_mv[47:16],
                                            // percent_x100[63:48], scaled_mv[95:64]
  output logic                  out_tuser   // ready_res
);

  cfg_t     cfg;
  logic     push;
  q_item_t  push_item;
  logic     q_full;
  logic     q_empty;
  logic     pop;
  q_item_t  head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  asa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  asa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  asa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  asa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/asa_front.sv
module asa_front import asa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  q_full,
  output logic                  push,
  output q_item_t               push_item,
  output cfg_t                  cfg
);

  cfg_t              cfg_r, cfg_nxt;
  logic [TIME_W-1:0] start_mark_r, start_mark_nxt;
  logic              mark_valid_r, mark_valid_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  logic [TIME_W-1:0]   now;
  logic [SAMPLE_W-1:0] smp;
  logic [TIME_W-1:0]   mark_eff;
  logic [TIME_W-1:0]   elapsed;
  logic                acc;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign push      = acc;

  assign now      = in_tdata[TIME_W-1:0];
  assign smp      = in_tdata[IN_W-1:TIME_W];
  assign mark_eff = mark_valid_r ? start_mark_r : now;
  assign elapsed  = now - mark_eff;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:      cfg_nxt.enable         = cfg_data[0];
        REG_INTERVAL:    cfg_nxt.interval_ms    = cfg_data[31:0];
        REG_NUM_SAMPLES: cfg_nxt.num_samples    = cfg_data[7:0];
        REG_MAX_VCC:     cfg_nxt.max_vcc_mv     = cfg_data[15:0];
        REG_NEG_RES:     cfg_nxt.neg_resolution = cfg_data[15:0];
        REG_DIV_RA:      cfg_nxt.divider_ra     = cfg_data[15:0];
        REG_DIV_RB:      cfg_nxt.divider_rb     = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // mark, accumulate and classify each request
  always_comb begin
    start_mark_nxt = start_mark_r;
    mark_valid_nxt = mark_valid_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    push_item.fin  = 1'b0;
    push_item.sum  = sum_r;
    push_item.n    = cfg_r.num_samples;
    if (acc && cfg_r.enable) begin
      if (!mark_valid_r) begin
        start_mark_nxt = now;
        mark_valid_nxt = 1'b1;
      end
      if (elapsed >= cfg_r.interval_ms) begin
        if (count_r < cfg_r.num_samples) begin
          sum_nxt   = sum_r + {{(SUM_W-SAMPLE_W){1'b0}}, smp};
          count_nxt = count_r + 1'b1;
        end else begin
          push_item.fin  = 1'b1;
          count_nxt      = '0;
          sum_nxt        = '0;
          mark_valid_nxt = 1'b0;
          start_mark_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= 1'b0;
      cfg_r.interval_ms    <= '0;
      cfg_r.num_samples    <= NUM_SAMPLES_RST;
      cfg_r.max_vcc_mv     <= MAX_VCC_RST;
      cfg_r.neg_resolution <= NEG_RES_RST;
      cfg_r.divider_ra     <= '0;
      cfg_r.divider_rb     <= '0;
      start_mark_r         <= '0;
      mark_valid_r         <= 1'b0;
      count_r              <= '0;
      sum_r                <= '0;
    end else begin
      cfg_r        <= cfg_nxt;
      start_mark_r <= start_mark_nxt;
      mark_valid_r <= mark_valid_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule

// File: rtl/asa_fifo.sv
module asa_fifo import asa_pkg::*; #(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output q_item_t head,
  output logic    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty)
    else $error("queue empty after a write");

endmodule

// File: rtl/asa_div.sv
module asa_div import asa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVD_W-1:0]    q_r, q_nxt;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DIVS_W:0] shifted;
  logic [DIVS_W:0] diff;
  logic            ge;

  // one restoring step per cycle, quotient bits shift in from the right
  assign shifted = {rem_r, q_r[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DIV_CNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIVD_W-2:0], ge};
      rem_nxt = ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

// File: rtl/asa_back.sv
module asa_back import asa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_empty,
  input  q_item_t          head,
  output logic             pop,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tuser
);

  bk_state_t         state_r, state_nxt;
  logic              launch_r, launch_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [RAW_W-1:0]  raw_r, raw_nxt;
  logic              neg_r, neg_nxt;
  logic [15:0]       mag_r, mag_nxt;
  logic [DIVD_W-1:0] prod_r, prod_nxt;
  logic [30:0]       volt_mag_r, volt_mag_nxt;
  logic [13:0]       pct_mag_r, pct_mag_nxt;
  logic [DIVD_W-1:0] scl_mag_r, scl_mag_nxt;
  logic [RAW_W-1:0]  last_raw_r, last_raw_nxt;
  logic [VOLT_W-1:0] last_volt_r, last_volt_nxt;
  logic [PCT_W-1:0]  last_pct_r, last_pct_nxt;
  logic [VOLT_W-1:0] last_scl_r, last_scl_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;

  logic              out_free;
  logic [RAW_W-1:0]  q_raw;
  logic [31:0]       volt_prod;
  logic [29:0]       pct_prod;
  logic [16:0]       r_sum;
  logic [DIVD_W-1:0] scl_prod;
  logic [15:0]       nr_eff;
  logic [15:0]       n_eff;
  logic [VOLT_W-1:0] volt_s;
  logic [PCT_W-1:0]  pct_s;
  logic [VOLT_W-1:0] scl_sat;
  logic [VOLT_W-1:0] scl_s;
  logic [17:0]       pfs_r1;
  logic [15:0]       pfs_r2;
  logic              pfs_fix;
  logic [31:0]       pfs_q;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // multipliers feed prod_r only
  assign q_raw     = div_rsp.quotient[RAW_W-1:0];
  assign volt_prod = {16'd0, cfg.max_vcc_mv} * {16'd0, mag_r};
  assign pct_prod  = {14'd0, mag_r} * {16'd0, PCT_SCALE};
  assign r_sum     = {1'b0, cfg.divider_ra} + {1'b0, cfg.divider_rb};
  assign scl_prod  = {17'd0, volt_mag_r} * {31'd0, r_sum};

  // divide prod_r by positive full scale (2^15 - 1): fold the high part back in twice
  assign pfs_r1  = {3'd0, prod_r[14:0]} + {1'b0, prod_r[31:15]};
  assign pfs_r2  = {1'b0, pfs_r1[14:0]} + {13'd0, pfs_r1[17:15]};
  assign pfs_fix = (pfs_r2 >= POS_FULL_SCALE);
  assign pfs_q   = {15'd0, prod_r[31:15]} + {29'd0, pfs_r1[17:15]} + {31'd0, pfs_fix};

  // zero divisors stand for one
  assign nr_eff = (cfg.neg_resolution == '0) ? 16'd1 : cfg.neg_resolution;
  assign n_eff  = (n_r == '0) ? 16'd1 : {8'd0, n_r};

  // signed results and saturation
  assign volt_s = neg_r ? (32'd0 - {1'b0, volt_mag_r}) : {1'b0, volt_mag_r};
  assign pct_s  = neg_r ? (16'd0 - {2'b0, pct_mag_r}) : {2'b0, pct_mag_r};

  always_comb begin
    if (!neg_r) begin
      scl_sat = (scl_mag_r > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : scl_mag_r[31:0];
    end else begin
      scl_sat = (scl_mag_r > 48'h0000_8000_0000) ? 32'h8000_0000
                                                   : (32'd0 - scl_mag_r[31:0]);
    end
  end

  assign scl_s = (cfg.divider_rb != '0) ? scl_sat : volt_s;

  // divider operand select
  always_comb begin
    div_req.start    = launch_r;
    div_req.dividend = prod_r;
    div_req.divisor  = POS_FULL_SCALE;
    case (state_r)
      BK_AVG:  begin
        div_req.dividend = {{(DIVD_W-SUM_W){1'b0}}, sum_r};
        div_req.divisor  = n_eff;
      end
      BK_VDIV: div_req.divisor = neg_r ? nr_eff : POS_FULL_SCALE;
      BK_PDIV: div_req.divisor = POS_FULL_SCALE;
      BK_SDIV: div_req.divisor = cfg.divider_rb;
      default: div_req.divisor = POS_FULL_SCALE;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    raw_nxt       = raw_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    volt_mag_nxt  = volt_mag_r;
    pct_mag_nxt   = pct_mag_r;
    scl_mag_nxt   = scl_mag_r;
    last_raw_nxt  = last_raw_r;
    last_volt_nxt = last_volt_r;
    last_pct_nxt  = last_pct_r;
    last_scl_nxt  = last_scl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    pop           = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (head.fin) begin
            sum_nxt    = head.sum;
            n_nxt      = head.n;
            pop        = 1'b1;
            launch_nxt = 1'b1;
            state_nxt  = BK_AVG;
          end else if (out_free) begin
            pop           = 1'b1;
            out_valid_nxt = 1'b1;
            out_user_nxt  = 1'b0;
            out_data_nxt  = {last_scl_r, last_pct_r, last_volt_r, last_raw_r};
          end
        end
      end
      BK_AVG: begin
        if (div_rsp.done) begin
          raw_nxt   = q_raw;
          neg_nxt   = (q_raw > POS_FULL_SCALE);
          mag_nxt   = (q_raw > POS_FULL_SCALE) ? (WRAP_SCALE - q_raw) : q_raw;
          state_nxt = BK_VMUL;
        end
      end
      BK_VMUL: begin
        // only the negative range needs the shared divider
        prod_nxt   = {16'd0, volt_prod};
        launch_nxt = neg_r;
        state_nxt  = BK_VDIV;
      end
      BK_VDIV: begin
        if (!neg_r) begin
          volt_mag_nxt = pfs_q[30:0];
          state_nxt    = BK_PMUL;
        end else if (div_rsp.done) begin
          volt_mag_nxt = div_rsp.quotient[30:0];
          state_nxt    = BK_PMUL;
        end
      end
      BK_PMUL: begin
        prod_nxt  = {18'd0, pct_prod};
        state_nxt = BK_PDIV;
      end
      BK_PDIV: begin
        pct_mag_nxt = pfs_q[13:0];
        state_nxt   = (cfg.divider_rb != '0) ? BK_SMUL : BK_EMIT;
      end
      BK_SMUL: begin
        prod_nxt   = scl_prod;
        launch_nxt = 1'b1;
        state_nxt  = BK_SDIV;
      end
      BK_SDIV: begin
        if (div_rsp.done) begin
          scl_mag_nxt = div_rsp.quotient;
          state_nxt   = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          last_raw_nxt  = raw_r;
          last_volt_nxt = volt_s;
          last_pct_nxt  = pct_s;
          last_scl_nxt  = scl_s;
          out_valid_nxt = 1'b1;
          out_user_nxt  = 1'b1;
          out_data_nxt  = {scl_s, pct_s, volt_s, raw_r};
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      launch_r    <= 1'b0;
      last_raw_r  <= '0;
      last_volt_r <= '0;
      last_pct_r  <= '0;
      last_scl_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      last_raw_r  <= last_raw_nxt;
      last_volt_r <= last_volt_nxt;
      last_pct_r  <= last_pct_nxt;
      last_scl_r  <= last_scl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    n_r        <= n_nxt;
    raw_r      <= raw_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    prod_r     <= prod_nxt;
    volt_mag_r <= volt_mag_nxt;
    pct_mag_r  <= pct_mag_nxt;
    scl_mag_r  <= scl_mag_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == BK_AVG || state_r == BK_VDIV ||
                      state_r == BK_PDIV || state_r == BK_SDIV))
    else $error("divider result outside a wait state");

  a_launch_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> (state_r == BK_AVG || state_r == BK_VDIV ||
                  state_r == BK_PDIV || state_r == BK_SDIV))
    else $error("divider launched outside a wait state");

  a_fin_starts_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.fin) |=> (state_r == BK_AVG && launch_r))
    else $error("finishing request did not start the average");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import asa_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int IDLE_WAIT   = 4;
  localparam int N_PHASES    = 13;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic        ready;
    logic [15:0] raw;
    logic [31:0] volt;
    logic [15:0] pct;
    logic [31:0] scaled;
  } reading_t;

  // predicts one reading report per request and checks it against the stream
  class reading_scoreboard;
    logic        en;
    logic [31:0] ivl;
    logic [7:0]  nsamp;
    logic [15:0] vcc, nres, ra, rb;
    logic [31:0] mark;
    logic        mark_set;
    logic [7:0]  cnt;
    logic [23:0] sum;
    reading_t    last;
    reading_t    report_q[$];
    int          mismatches, requests, results, readings;

    function new();
      en = 1'b0;
      ivl = '0;
      nsamp = NUM_SAMPLES_RST;
      vcc = MAX_VCC_RST;
      nres = NEG_RES_RST;
      ra = '0;
      rb = '0;
      mark = '0;
      mark_set = 1'b0;
      cnt = '0;
      sum = '0;
      last = '0;
      mismatches = 0;
      requests = 0;
      results = 0;
      readings = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_ENABLE:      en = val[0];
        REG_INTERVAL:    ivl = val;
        REG_NUM_SAMPLES: nsamp = val[7:0];
        REG_MAX_VCC:     vcc = val[15:0];
        REG_NEG_RES:     nres = val[15:0];
        REG_DIV_RA:      ra = val[15:0];
        REG_DIV_RB:      rb = val[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // average, millivolts, percent and divider correction of the held sum
    function void convert_average();
      logic [23:0] dv, avg;
      longint raw, volt, pct, scl, d, nr, pos, wrap, pscale, vcc_l, ra_l, rb_l, v;
      dv = (nsamp == 0) ? 24'd1 : {16'd0, nsamp};
      avg = sum / dv;
      raw = longint'(avg[15:0]);
      pos = longint'(POS_FULL_SCALE);
      wrap = longint'(WRAP_SCALE);
      pscale = longint'(PCT_SCALE);
      vcc_l = longint'(vcc);
      ra_l = longint'(ra);
      rb_l = longint'(rb);
      if (raw <= pos) begin
        volt = (vcc_l * raw) / pos;
        pct = (raw * pscale) / pos;
      end else begin
        // above positive full scale: counted down from the wrap value
        d = wrap - raw;
        if (nres == 0) nr = 1;
        else nr = longint'(nres);
        volt = -((vcc_l * d) / nr);
        pct = -((d * pscale) / pos);
      end
      if (rb != 0) scl = (volt * (ra_l + rb_l)) / rb_l;
      else scl = volt;
      last.raw = raw[15:0];
      v = clamp(volt, -64'sd2147483648, 64'sd2147483647);
      last.volt = v[31:0];
      v = clamp(pct, -64'sd32768, 64'sd32767);
      last.pct = v[15:0];
      v = clamp(scl, -64'sd2147483648, 64'sd2147483647);
      last.scaled = v[31:0];
    endfunction

    function void note_request(logic [31:0] t, logic [15:0] s);
      logic [31:0] gap;
      reading_t    rep;
      requests++;
      rep = last;
      rep.ready = 1'b0;
      if (en) begin
        if (!mark_set) begin
          mark = t;
          mark_set = 1'b1;
        end
        gap = t - mark;
        if (gap >= ivl) begin
          if (cnt < nsamp) begin
            sum = sum + {8'd0, s};
            cnt = cnt + 8'd1;
          end else begin
            convert_average();
            cnt = '0;
            sum = '0;
            mark = '0;
            mark_set = 1'b0;
            rep = last;
            rep.ready = 1'b1;
          end
        end
      end
      report_q.push_back(rep);
    endfunction

    function void check_result(logic user, logic [OUT_W-1:0] data);
      reading_t got, rep;
      got.ready = user;
      got.raw = data[15:0];
      got.volt = data[47:16];
      got.pct = data[63:48];
      got.scaled = data[95:64];
      results++;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request waiting", results);
        return;
      end
      rep = report_q.pop_front();
      if (rep.ready) readings++;
      if (got.ready !== rep.ready || got.raw !== rep.raw || got.volt !== rep.volt ||
          got.pct !== rep.pct || got.scaled !== rep.scaled) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp ready=%0d raw=%0d mv=%0d pct=%0d scaled=%0d",
                   results, rep.ready, rep.raw, $signed(rep.volt), $signed(rep.pct),
                   $signed(rep.scaled));
        if (mismatches <= 10)
          $display("            got ready=%0d raw=%0d mv=%0d pct=%0d scaled=%0d",
                   got.ready, got.raw, $signed(got.volt), $signed(got.pct),
                   $signed(got.scaled));
      end
    endfunction

    function int pending();
      return report_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // time_ms[31:0], sample[47:32]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // raw_avg[15:0], voltage_mv[47:16],
                                     // percent_x100[63:48], scaled_mv[95:64]
  logic                  out_tuser;  // ready_res

  int snd_idle_pct;
  int rcv_stall_pct;
  int cycles;
  reading_scoreboard sb;

  adc_sample_averager_scaler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= rcv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one request with random sender gaps in front of it
  task automatic send_item(input logic [31:0] t, input logic [15:0] s);
    @(negedge clk);
    while ($urandom_range(99, 0) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s, t};
    do @(posedge clk); while (!in_tready);
    sb.note_request(t, s);
  endtask

  // hold the sender until every report is back and the block is quiet
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  initial begin
    int          p, k, n_items, jump_pct;
    logic [31:0] t, w;
    logic [15:0] level, s;

    sb = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // disabled after reset: the zero reading repeats
    send_item(32'hFFFF_FFFF, 16'hFFFF);
    drain_results();
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_INTERVAL, 32'd5);
    write_reg(REG_NUM_SAMPLES, 32'd2);

    // start mark at time zero, wait out the interval, full-scale samples
    send_item(32'd0, 16'h1234);
    send_item(32'd3, 16'hFFFF);
    send_item(32'd5, 16'hFFFF);
    send_item(32'd6, 16'hFFFF);
    send_item(32'd7, 16'h0000);

    // negative range with zero divisor, divider pushes into saturation
    drain_results();
    write_reg(REG_NEG_RES, 32'd0);
    write_reg(REG_MAX_VCC, 32'd65535);
    write_reg(REG_INTERVAL, 32'd0);
    write_reg(REG_NUM_SAMPLES, 32'd1);
    write_reg(REG_DIV_RA, 32'd65535);
    write_reg(REG_DIV_RB, 32'd1);
    send_item(32'd10, 16'd40000);
    send_item(32'd11, 16'd0);

    // zero sample count finishes at once with raw zero
    drain_results();
    write_reg(REG_DIV_RA, 32'd0);
    write_reg(REG_DIV_RB, 32'd65535);
    write_reg(REG_NUM_SAMPLES, 32'd0);
    send_item(32'd20, 16'hAAAA);
    send_item(32'd21, 16'h5555);

    // both sides of the positive full-scale boundary
    drain_results();
    write_reg(REG_NUM_SAMPLES, 32'd1);
    write_reg(REG_DIV_RB, 32'd0);
    send_item(32'd30, 16'd32767);
    send_item(32'd31, 16'd32768);
    send_item(32'd32, 16'd32768);
    send_item(32'd33, 16'd0);

    // longest interval and time stamp wrap
    drain_results();
    write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
    send_item(32'd0, 16'd1);
    send_item(32'hFFFF_FFFE, 16'd2);
    send_item(32'hFFFF_FFFF, 16'hFFFF);
    send_item(32'd5, 16'd0);

    // random phases, each with its own settings and idling
    for (p = 0; p < N_PHASES; p++) begin
      drain_results();
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 64; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 64; end
        default: begin snd_idle_pct = 17; rcv_stall_pct = 17; end
      endcase

      w = $urandom();
      w[0] = (p != 5);
      write_reg(REG_ENABLE, w);
      if (p == 4 || p == 11) w = $urandom();
      else if (p == 9) w = 32'hFFFF_FFFF;
      else w = $urandom_range(20, 0);
      write_reg(REG_INTERVAL, w);
      w = $urandom();
      if (p == 2) w[7:0] = 8'd0;
      else if (p == 7) w[7:0] = 8'd255;
      else if (p == 10) w[7:0] = 8'($urandom_range(255, 0));
      else w[7:0] = 8'($urandom_range(8, 1));
      write_reg(REG_NUM_SAMPLES, w);
      w = $urandom();
      if (p == 1) w[15:0] = 16'd0;
      else if (p == 3) w[15:0] = 16'hFFFF;
      write_reg(REG_MAX_VCC, w);
      w = $urandom();
      if (p == 6) w[15:0] = 16'd0;
      else if (p == 8) w[15:0] = 16'd1;
      write_reg(REG_NEG_RES, w);
      w = $urandom();
      if (p == 4) w[15:0] = 16'hFFFF;
      write_reg(REG_DIV_RA, w);
      w = $urandom();
      if (p == 4) w[15:0] = 16'd1;
      else if (p % 3 == 0) w[15:0] = 16'd0;
      write_reg(REG_DIV_RB, w);
      if (p == 8) write_reg(REG_NONE, $urandom());

      n_items = (p == 7) ? 300 : 80;
      t = (p == 6) ? 32'hFFFF_FFC0 : $urandom();
      jump_pct = (p == 4 || p == 9 || p == 11) ? 50 : 8;
      level = 16'($urandom());
      for (k = 0; k < n_items; k++) begin
        if (k == n_items / 2) drain_results();
        // mostly a steady clock with a slowly moving level, some jumps and noise
        if ($urandom_range(99, 0) < jump_pct) t = $urandom();
        else t = t + $urandom_range(4, 0);
        if ($urandom_range(19, 0) == 0) level = 16'($urandom());
        if ($urandom_range(99, 0) < 70) s = level + 16'($urandom_range(255, 0));
        else s = 16'($urandom());
        send_item(t, s);
      end
    end

    drain_results();
    repeat (IDLE_WAIT) @(posedge clk);
    $display("covered %0d requests: directed cases and %0d random settings, %0d readings",
             sb.requests, N_PHASES, sb.readings);
    $display("%0d results checked, %0d mismatches", sb.results, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
